@@ design/fpba_pkg.sv @@
`default_nettype none

package fpba_pkg;

    // Default sizing of the partition table.
    localparam int DEF_MAX_BLOCKS = 64;
    localparam int DEF_SIZE_WIDTH = 16;

    // Fixed field widths of the stream words and the configuration port.
    localparam int INDEX_WIDTH     = 6;
    localparam int POLICY_WIDTH    = 2;
    localparam int COUNT_WIDTH     = 7;
    localparam int CFG_INDEX_WIDTH = 1;

    // Reset value of the scanned partition count.
    localparam logic [COUNT_WIDTH-1:0] RESET_BLOCKS_IN_USE = 7'd64;

    // Placement policies; the unused code behaves as first fit.
    typedef enum logic [POLICY_WIDTH-1:0] {
        POLICY_FIRST = 2'd0,
        POLICY_BEST  = 2'd1,
        POLICY_WORST = 2'd2
    } policy_t;

    // Kind of an input word.
    typedef enum logic {
        MODE_LOAD    = 1'b0,
        MODE_REQUEST = 1'b1
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_FIT_POLICY    = 1'b0,
        REG_BLOCKS_IN_USE = 1'b1
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ design/fpba_free_ram.sv @@
`default_nettype none

module fpba_free_ram #(
    parameter int DEPTH      = 64,
    parameter int ADDR_WIDTH = 6,
    parameter int DATA_WIDTH = 16
)(
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [ADDR_WIDTH-1:0] waddr,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    input  wire logic                  re,
    input  wire logic [ADDR_WIDTH-1:0] raddr,
    output logic      [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // One write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // One read port with registered data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/fit_policy_block_allocator.sv @@
`default_nettype none

// Partition allocator with first, best and worst fit placement.
// Input words arrive on s_tvalid/s_tready. s_tuser = 0 loads the free size in
// s_tdata into partition block_index; s_tuser = 1 requests size units.
// Each input word gives exactly one result word on m_tvalid/m_tready:
// m_tuser is the grant flag, m_tdata the partition and the size left in it.
// Registers are written on cfg_valid/cfg_ready (always ready); the user must
// write them only while idle, as the block does not check the state. Index 0
// is the fit policy, index 1 the number of partitions scanned. A load writes its
// entry at acceptance when block_index is in range. A request scans
// min(blocks_in_use, MAX_BLOCKS) partitions, possibly none: the free-size memory
// is read one entry per cycle through its single read port, then the chosen
// entry is written back. The result then goes to the output register.
// One word is in work at a time; the next one is accepted once the result
// of the current one sits in the output register, even if that is stalled.
// While the receiver holds m_tready low the result waits in the output
// register and a finished next result waits in the sequencer.
// Reset sets first fit and 64 partitions; the free-size memory holds
// nothing valid until each partition in use has been loaded.
module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int SIZE_WIDTH = DEF_SIZE_WIDTH
)(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // mode
    input  wire logic                       s_tuser,
    // block_index, size, zero padding
    input  wire logic [((INDEX_WIDTH + SIZE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // granted
    output logic                            m_tuser,
    // block_number, remaining, zero padding
    output logic      [((INDEX_WIDTH + SIZE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [COUNT_WIDTH-1:0]     cfg_data
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int XW = (AW > INDEX_WIDTH) ? AW : INDEX_WIDTH;
    localparam int TDATA_WIDTH = ((INDEX_WIDTH + SIZE_WIDTH + 7) / 8) * 8;

    state_t state_reg, state_next;

    logic [POLICY_WIDTH-1:0] fit_policy_reg;
    logic [COUNT_WIDTH-1:0]  blocks_in_use_reg;

    logic [SIZE_WIDTH-1:0]  req_size_reg, req_size_next;
    logic [CW-1:0]          scan_len_reg, scan_len_next;
    logic [CW-1:0]          rd_cnt_reg, rd_cnt_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                   found_reg, found_next;
    logic [AW-1:0]          pick_idx_reg, pick_idx_next;
    logic [SIZE_WIDTH-1:0]  pick_val_reg, pick_val_next;
    logic                   res_granted_reg, res_granted_next;
    logic [INDEX_WIDTH-1:0] res_index_reg, res_index_next;
    logic [SIZE_WIDTH-1:0]  res_remaining_reg, res_remaining_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_granted_reg, m_granted_next;
    logic [INDEX_WIDTH-1:0] m_index_reg, m_index_next;
    logic [SIZE_WIDTH-1:0]  m_remaining_reg, m_remaining_next;

    logic                   in_mode;
    logic [INDEX_WIDTH-1:0] in_index;
    logic [SIZE_WIDTH-1:0]  in_size;
    logic                   in_accept;
    logic                   load_ok;
    logic [XW-1:0]          in_index_wide;
    logic [XW-1:0]          pick_wide;
    logic [CW-1:0]          scan_len_in;
    logic                   issue;
    logic                   take;
    logic                   out_load;
    logic [SIZE_WIDTH-1:0]  left_size;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SIZE_WIDTH-1:0]  ram_wdata;
    logic                   ram_re;
    logic [SIZE_WIDTH-1:0]  ram_rdata;

    // Input word fields.
    assign in_mode       = s_tuser;
    assign in_index      = s_tdata[INDEX_WIDTH-1:0];
    assign in_size       = s_tdata[INDEX_WIDTH+SIZE_WIDTH-1:INDEX_WIDTH];
    assign in_accept     = s_tvalid && s_tready;
    assign in_index_wide = XW'(in_index);
    assign load_ok       = (32'(in_index) < MAX_BLOCKS);
    assign pick_wide     = XW'(pick_idx_reg);
    assign left_size     = pick_val_reg - req_size_reg;

    // Scan length saturates at the table depth.
    assign scan_len_in = (32'(blocks_in_use_reg) > MAX_BLOCKS) ? CW'(MAX_BLOCKS)
                                                               : CW'(blocks_in_use_reg);

    // A read is issued for every partition still to be scanned.
    assign issue = (rd_cnt_reg < scan_len_reg);

    // Decide whether the entry just read replaces the current pick.
    always_comb
    begin
        take = 1'b0;
        if (cmp_valid_reg && (ram_rdata >= req_size_reg))
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (fit_policy_reg == POLICY_BEST)
            begin
                take = (ram_rdata < pick_val_reg);
            end
            else if (fit_policy_reg == POLICY_WORST)
            begin
                take = (ram_rdata > pick_val_reg);
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (in_mode == MODE_LOAD) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue && !cmp_valid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and memory port controls.
    always_comb
    begin
        s_tready  = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = pick_idx_reg;
        ram_wdata = left_size;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && (in_mode == MODE_LOAD) && load_ok)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = in_index_wide[AW-1:0];
                    ram_wdata = in_size;
                end
            end
            ST_SCAN:
            begin
                ram_re = issue;
            end
            ST_FINISH:
            begin
                ram_we = found_reg;
            end
            ST_DONE:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        req_size_next      = req_size_reg;
        scan_len_next      = scan_len_reg;
        rd_cnt_next        = rd_cnt_reg;
        cmp_valid_next     = 1'b0;
        cmp_idx_next       = cmp_idx_reg;
        found_next         = found_reg;
        pick_idx_next      = pick_idx_reg;
        pick_val_next      = pick_val_reg;
        res_granted_next   = res_granted_reg;
        res_index_next     = res_index_reg;
        res_remaining_next = res_remaining_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    req_size_next      = in_size;
                    scan_len_next      = scan_len_in;
                    rd_cnt_next        = '0;
                    found_next         = 1'b0;
                    res_granted_next   = 1'b0;
                    res_index_next     = in_index;
                    res_remaining_next = in_size;
                end
            end
            ST_SCAN:
            begin
                cmp_valid_next = issue;
                cmp_idx_next   = rd_cnt_reg[AW-1:0];
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                end
                if (take)
                begin
                    found_next    = 1'b1;
                    pick_idx_next = cmp_idx_reg;
                    pick_val_next = ram_rdata;
                end
            end
            ST_FINISH:
            begin
                if (found_reg)
                begin
                    res_granted_next   = 1'b1;
                    res_index_next     = pick_wide[INDEX_WIDTH-1:0];
                    res_remaining_next = left_size;
                end
                else
                begin
                    res_granted_next   = 1'b0;
                    res_index_next     = '0;
                    res_remaining_next = '0;
                end
            end
            default:
            begin
                cmp_valid_next = 1'b0;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        m_tvalid_next    = m_tvalid_reg;
        m_granted_next   = m_granted_reg;
        m_index_next     = m_index_reg;
        m_remaining_next = m_remaining_reg;
        if (out_load)
        begin
            m_tvalid_next    = 1'b1;
            m_granted_next   = res_granted_reg;
            m_index_next     = res_index_reg;
            m_remaining_next = res_remaining_reg;
        end
        else if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cmp_valid_reg     <= 1'b0;
            found_reg         <= 1'b0;
            rd_cnt_reg        <= '0;
            scan_len_reg      <= '0;
            m_tvalid_reg      <= 1'b0;
            fit_policy_reg    <= POLICY_FIRST;
            blocks_in_use_reg <= RESET_BLOCKS_IN_USE;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            rd_cnt_reg    <= rd_cnt_next;
            scan_len_reg  <= scan_len_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FIT_POLICY:
                    begin
                        fit_policy_reg <= cfg_data[POLICY_WIDTH-1:0];
                    end
                    REG_BLOCKS_IN_USE:
                    begin
                        blocks_in_use_reg <= cfg_data;
                    end
                    default:
                    begin
                        fit_policy_reg <= fit_policy_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_size_reg      <= req_size_next;
        cmp_idx_reg       <= cmp_idx_next;
        pick_idx_reg      <= pick_idx_next;
        pick_val_reg      <= pick_val_next;
        res_granted_reg   <= res_granted_next;
        res_index_reg     <= res_index_next;
        res_remaining_reg <= res_remaining_next;
        m_granted_reg     <= m_granted_next;
        m_index_reg       <= m_index_next;
        m_remaining_reg   <= m_remaining_next;
    end

    // Free-size table.
    fpba_free_ram #(
        .DEPTH      (MAX_BLOCKS),
        .ADDR_WIDTH (AW),
        .DATA_WIDTH (SIZE_WIDTH)
    ) u_free_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Port drive.
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_granted_reg;
    assign m_tdata   = TDATA_WIDTH'({m_remaining_reg, m_index_reg});

`ifndef ASSERT_OFF
    // The read counter never runs past the scan length.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rd_cnt_reg <= scan_len_reg))
        else $error("read counter beyond scan length");

    // A held pick always fits the request, so the write-back cannot wrap.
    a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && (state_reg == ST_SCAN || state_reg == ST_FINISH))
            |-> (pick_val_reg >= req_size_reg))
        else $error("picked partition smaller than request");

    // A finished result waits while the output register is stalled.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_tvalid && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result left the sequencer while output stalled");

    // Memory writes happen only at a load acceptance or at the write-back step.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_IDLE && in_accept) || state_reg == ST_FINISH))
        else $error("unexpected free-size write");
`endif

endmodule

`default_nettype wire
